[design/ibm_pkg.sv]
// Shared constants, opcodes and helper types for the IoU box matcher.
package ibm_pkg;

  localparam int unsigned MaxClusters = 64;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned ScoreW      = 18;
  localparam int unsigned CoordW      = 12;

  // Numerator and denominator widths of the widest ratio (area IoU).
  localparam int unsigned DenW = 2 * CoordW + 1;
  localparam int unsigned NumW = 2 * CoordW + FracBits;

  localparam logic [ScoreW-1:0] ThreshReset = ScoreW'(6554);

  typedef enum logic [2:0] {
    OP_SET_SEM  = 3'd0,
    OP_NEW_CAM  = 3'd1,
    OP_LOAD_BOX = 3'd2,
    OP_MATCH    = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_EN_AREA = 3'd0,
    REG_EN_X    = 3'd1,
    REG_EN_Y    = 3'd2,
    REG_KEEP    = 3'd3,
    REG_THRESH  = 3'd4
  } reg_e;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [FracBits:0] quot;
  } div_rsp_t;

endpackage

[design/ibm_divider.sv]
// Restoring divider, one quotient bit per cycle, for the IoU ratios.
module ibm_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ibm_pkg::div_req_t req_i,
  output ibm_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW = ibm_pkg::FracBits + 1;
  localparam int unsigned NW = ibm_pkg::NumW;
  localparam int unsigned DW = ibm_pkg::DenW;
  localparam int unsigned CW = $clog2(QW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [DW:0]   trial;

  // Ratios never exceed one, so the upper numerator bits fold into the
  // remainder before the first quotient bit.
  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DW-1:0], num_q[NW-1]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = (DW+1)'(req_i.num[NW-1:QW]);
      num_d  = {req_i.num[QW-1:0], (NW-QW)'(0)};
      den_d  = req_i.den;
      quot_d = '0;
      cnt_d  = CW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        rem_d  = trial;
        quot_d = {quot_q[QW-2:0], 1'b1};
      end else begin
        rem_d  = {rem_q[DW-1:0], num_q[NW-1]};
        quot_d = {quot_q[QW-2:0], 1'b0};
      end
      num_d = {num_q[NW-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[design/iou_box_matcher.sv]
// Top level of the IoU box matcher: cluster memories and match sequencer.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  request | req_valid_i, req_stall_o, op fields     | in
//  result  | rsp_valid_o, rsp_stall_i, result fields | out
//  config  | cfg_valid_i, cfg_ready_o, index, data   | in
//
// Set, load and new-camera requests step through S_RD, S_OUT and S_FINISH; a
// read steps through S_RD, S_SEMRD, S_APPLY and S_FINISH. A match reads each of
// the 64 cluster entries in turn and, for every valid one that is not disjoint,
// runs up to three divisions on the shared divider, each holding the sequencer.
// Reset clears control state and valid bits at once; the semantic memory is
// cleared by a pass over all 64 entries after reset, during which no request
// is taken. The result sits in an output register; a new request is taken
// once it has been delivered.
module iou_box_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [5:0]  cluster_index_i,
  input  logic [11:0] box_x_i,
  input  logic [11:0] box_y_i,
  input  logic [11:0] box_width_i,
  input  logic [11:0] box_height_i,
  input  logic [7:0]  label_i,
  input  logic [15:0] confidence_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic        matched_o,
  output logic [5:0]  match_index_o,
  output logic        applied_o,
  output logic [17:0] best_score_o,
  output logic [7:0]  out_label_o,
  output logic [15:0] out_confidence_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);

  localparam int unsigned N  = ibm_pkg::MaxClusters;
  localparam int unsigned IW = ibm_pkg::IdxW;
  localparam int unsigned CW = ibm_pkg::CoordW;
  localparam int unsigned SW = ibm_pkg::ScoreW;
  localparam int unsigned DW = ibm_pkg::DenW;
  localparam int unsigned NW = ibm_pkg::NumW;
  localparam int unsigned FB = ibm_pkg::FracBits;

  // Sequencer states.
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RD     = 4'd2;  // memory read issued
  localparam logic [3:0] S_GEOM   = 4'd3;  // box data back, edges computed
  localparam logic [3:0] S_OVL    = 4'd4;  // overlap and products
  localparam logic [3:0] S_DIVA   = 4'd5;
  localparam logic [3:0] S_DIVX   = 4'd6;
  localparam logic [3:0] S_DIVY   = 4'd7;
  localparam logic [3:0] S_WAIT   = 4'd8;
  localparam logic [3:0] S_NEXT   = 4'd9;
  localparam logic [3:0] S_SEMRD  = 4'd10;
  localparam logic [3:0] S_APPLY  = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;

  // Configuration registers.
  logic          en_area_q, en_x_q, en_y_q, keep_q;
  logic [SW-1:0] thresh_q;

  // Memories: boxes (no reset) and semantics (cleared by a sweep).
  logic [4*CW-1:0] box_mem [N];
  logic [23:0]     sem_mem [N];
  logic [4*CW-1:0] box_rd_q;
  logic [23:0]     sem_rd_q;
  logic [N-1:0]    valid_q;

  logic          box_we, sem_we;
  logic [IW-1:0] box_wa, sem_wa, box_ra, sem_ra;
  logic [4*CW-1:0] box_wd;
  logic [23:0]   sem_wd;

  logic [3:0]    state_q, state_d;
  logic [IW:0]   ptr_q, ptr_d;  // walk pointer, one wider to hold N
  logic [2:0]    op_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] dx_q, dy_q, dw_q, dh_q;
  logic [7:0]    lab_q;
  logic [15:0]   conf_q;

  logic [SW-1:0] best_q, best_d, score_q, score_d;
  logic [IW-1:0] besti_q, besti_d;

  // Per-cluster geometry registers.
  logic [CW:0]   ovx_q, ovy_q;
  logic          disj_q;
  logic [CW-1:0] cw_q, ch_q;
  logic [2*CW-1:0] inter_q, sa_q, sb_q;

  // Result register.
  logic          rvalid_q;
  logic          matched_q, applied_q;
  logic [IW-1:0] midx_q;
  logic [SW-1:0] rscore_q;
  logic [7:0]    rlab_q;
  logic [15:0]   rconf_q;

  ibm_pkg::div_req_t div_req;
  ibm_pkg::div_rsp_t div_rsp;

  ibm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  logic accept;
  assign req_stall_o = (state_q != S_IDLE) || rvalid_q;
  assign accept      = req_valid_i && !req_stall_o;
  assign cfg_ready_o = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_area_q <= 1'b0;
      en_x_q    <= 1'b1;
      en_y_q    <= 1'b0;
      keep_q    <= 1'b0;
      thresh_q  <= ibm_pkg::ThreshReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ibm_pkg::REG_EN_AREA: en_area_q <= cfg_data_i[0];
        ibm_pkg::REG_EN_X:    en_x_q    <= cfg_data_i[0];
        ibm_pkg::REG_EN_Y:    en_y_q    <= cfg_data_i[0];
        ibm_pkg::REG_KEEP:    keep_q    <= cfg_data_i[0];
        ibm_pkg::REG_THRESH:  thresh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    if (box_we) box_mem[box_wa] <= box_wd;
    box_rd_q <= box_mem[box_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sem_we) sem_mem[sem_wa] <= sem_wd;
    sem_rd_q <= sem_mem[sem_ra];
  end

  // Geometry of the cluster that the box memory just returned.
  logic [CW-1:0] bx, by, bw, bh;
  logic [CW:0]   lo_x, lo_y, ea_x, eb_x, ea_y, eb_y, hi_x, hi_y;
  assign {bx, by, bw, bh} = box_rd_q;
  always_comb begin
    lo_x = (bx > dx_q) ? {1'b0, bx} : {1'b0, dx_q};
    lo_y = (by > dy_q) ? {1'b0, by} : {1'b0, dy_q};
    ea_x = {1'b0, bx} + {1'b0, bw};
    eb_x = {1'b0, dx_q} + {1'b0, dw_q};
    ea_y = {1'b0, by} + {1'b0, bh};
    eb_y = {1'b0, dy_q} + {1'b0, dh_q};
    hi_x = (ea_x < eb_x) ? ea_x : eb_x;
    hi_y = (ea_y < eb_y) ? ea_y : eb_y;
  end

  // Divider operands for each ratio.
  logic [DW-1:0] den_area, den_x, den_y;
  assign den_area = ({1'b0, sa_q} + {1'b0, sb_q}) - {1'b0, inter_q};
  assign den_x = DW'({1'b0, cw_q} + {1'b0, dw_q} - ovx_q);
  assign den_y = DW'({1'b0, ch_q} + {1'b0, dh_q} - ovy_q);

  logic [2:0] pend_q, pend_d;  // ratios still to divide: area, x, y

  // Remembers whether the division in flight had a zero denominator.
  logic div_req_den_zero_q;

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    best_d  = best_q;
    besti_d = besti_q;
    score_d = score_q;
    pend_d  = pend_q;
    box_we  = 1'b0;
    box_wa  = idx_q;
    box_wd  = {dx_q, dy_q, dw_q, dh_q};
    sem_we  = 1'b0;
    sem_wa  = idx_q;
    sem_wd  = {lab_q, conf_q};
    box_ra  = ptr_q[IW-1:0];
    sem_ra  = idx_q;
    div_req = '0;
    unique case (state_q)
      S_CLEAR: begin
        sem_we = 1'b1;
        sem_wa = ptr_q[IW-1:0];
        sem_wd = '0;
        ptr_d  = ptr_q + (IW+1)'(1);
        if (ptr_q == (IW+1)'(N - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          ptr_d   = '0;
          best_d  = '0;
          besti_d = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        unique case (op_q)
          ibm_pkg::OP_SET_SEM: begin
            sem_we = 1'b1;
            sem_wd = keep_q ? {lab_q, conf_q} : 24'd0;
            state_d = S_OUT;
          end
          ibm_pkg::OP_LOAD_BOX: begin
            box_we  = 1'b1;
            state_d = S_OUT;
          end
          ibm_pkg::OP_READ:  state_d = S_SEMRD;
          ibm_pkg::OP_MATCH: begin
            if (ptr_q == (IW+1)'(N)) begin
              sem_ra  = besti_q;
              state_d = S_SEMRD;
            end else if (valid_q[ptr_q[IW-1:0]]) begin
              state_d = S_GEOM;
            end else begin
              ptr_d = ptr_q + (IW+1)'(1);
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      S_GEOM: state_d = S_OVL;
      S_OVL: begin
        score_d = '0;
        pend_d  = {en_area_q, en_x_q, en_y_q};
        state_d = disj_q ? S_NEXT : S_DIVA;
      end
      S_DIVA, S_DIVX, S_DIVY: begin
        if (pend_q[2]) begin
          div_req.start = 1'b1;
          div_req.num   = NW'({inter_q, FB'(0)});
          div_req.den   = den_area;
          pend_d[2]     = 1'b0;
          state_d       = S_WAIT;
        end else if (pend_q[1]) begin
          div_req.start = 1'b1;
          div_req.num   = NW'({ovx_q, FB'(0)});
          div_req.den   = den_x;
          pend_d[1]     = 1'b0;
          state_d       = S_WAIT;
        end else if (pend_q[0]) begin
          div_req.start = 1'b1;
          div_req.num   = NW'({ovy_q, FB'(0)});
          div_req.den   = den_y;
          pend_d[0]     = 1'b0;
          state_d       = S_WAIT;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          // A zero denominator leaves an all-ones quotient; it counts as 0.
          if (div_req_den_zero_q == 1'b0)
            score_d = score_q + SW'(div_rsp.quot);
          state_d = S_DIVA;
        end
      end
      S_NEXT: begin
        if (best_q < score_q) begin
          best_d  = score_q;
          besti_d = ptr_q[IW-1:0];
        end
        ptr_d   = ptr_q + (IW+1)'(1);
        state_d = S_RD;
      end
      S_SEMRD: begin
        sem_ra  = (op_q == ibm_pkg::OP_MATCH) ? besti_q : idx_q;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (op_q == ibm_pkg::OP_MATCH && best_q > thresh_q && sem_rd_q[15:0] <= conf_q) begin
          sem_we = 1'b1;
          sem_wa = besti_q;
        end
        state_d = S_FINISH;
      end
      S_OUT:    state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (div_req.start) div_req_den_zero_q <= (div_req.den == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      if (state_q == S_RD && op_q == ibm_pkg::OP_NEW_CAM) valid_q <= '0;
      if (box_we) valid_q[box_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q  <= best_d;
    besti_q <= besti_d;
    score_q <= score_d;
    pend_q  <= pend_d;
    if (accept) begin
      op_q   <= opcode_i;
      idx_q  <= cluster_index_i;
      dx_q   <= box_x_i;
      dy_q   <= box_y_i;
      dw_q   <= box_width_i;
      dh_q   <= box_height_i;
      lab_q  <= label_i;
      conf_q <= confidence_i;
    end
    if (state_q == S_GEOM) begin
      disj_q <= (hi_x < lo_x) || (hi_y < lo_y);
      ovx_q  <= hi_x - lo_x;
      ovy_q  <= hi_y - lo_y;
      cw_q   <= bw;
      ch_q   <= bh;
    end
    if (state_q == S_OVL) begin
      inter_q <= (2*CW)'(ovx_q[CW-1:0]) * (2*CW)'(ovy_q[CW-1:0]);
      sa_q    <= (2*CW)'(cw_q) * (2*CW)'(ch_q);
      sb_q    <= (2*CW)'(dw_q) * (2*CW)'(dh_q);
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (state_q == S_FINISH) begin
      rvalid_q <= 1'b1;
    end else if (rvalid_q && !rsp_stall_i) begin
      rvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_APPLY && op_q == ibm_pkg::OP_MATCH) begin
      matched_q <= best_q > thresh_q;
      applied_q <= best_q > thresh_q && sem_rd_q[15:0] <= conf_q;
      midx_q    <= besti_q;
      rscore_q  <= best_q;
      rlab_q    <= '0;
      rconf_q   <= '0;
    end else if (state_q == S_APPLY) begin
      matched_q <= 1'b0;
      applied_q <= 1'b0;
      midx_q    <= '0;
      rscore_q  <= '0;
      rlab_q    <= sem_rd_q[23:16];
      rconf_q   <= sem_rd_q[15:0];
    end else if (state_q == S_OUT) begin
      matched_q <= 1'b0;
      applied_q <= 1'b0;
      midx_q    <= '0;
      rscore_q  <= '0;
      rlab_q    <= '0;
      rconf_q   <= '0;
    end
  end

  assign rsp_valid_o      = rvalid_q;
  assign matched_o        = matched_q;
  assign match_index_o    = midx_q;
  assign applied_o        = applied_q;
  assign best_score_o     = rscore_q;
  assign out_label_o      = rlab_q;
  assign out_confidence_o = rconf_q;

`ifndef NO_ASSERTIONS
  a_apply_implies_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (!applied_o || matched_o))
    else $error("applied without match");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> req_stall_o)
    else $error("request taken while busy");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");
  a_result_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> rsp_valid_o)
    else $error("result lost");
`endif

endmodule

[tb/tb.sv]
// IoU box matcher testbench: directed and random framed traffic, checked by a scoreboard.
module tb;

  // One request as it is driven onto the request port.
  typedef struct {
    logic [2:0]  op;
    logic [5:0]  idx;
    logic [11:0] x, y, w, h;
    logic [7:0]  label;
    logic [15:0] conf;
  } box_req_t;

  // One result as it leaves the result port.
  typedef struct {
    logic        matched;
    logic [5:0]  match_index;
    logic        applied;
    logic [17:0] best_score;
    logic [7:0]  out_label;
    logic [15:0] out_confidence;
  } box_rsp_t;

  // Cluster table mirror. It follows every accepted request and queues the result
  // that request must produce; delivered results are checked against the queue head.
  class cluster_scoreboard;
    logic [11:0] bx[ibm_pkg::MaxClusters], by[ibm_pkg::MaxClusters];
    logic [11:0] bw[ibm_pkg::MaxClusters], bh[ibm_pkg::MaxClusters];
    bit          bvalid[ibm_pkg::MaxClusters];
    logic [7:0]  sem_label[ibm_pkg::MaxClusters];
    logic [15:0] sem_conf[ibm_pkg::MaxClusters];
    bit          en_area, en_x, en_y, keep_sem;
    logic [17:0] thresh;
    box_rsp_t    pending_rsp[$];
    int          errors;

    function void clear();
      for (int i = 0; i < ibm_pkg::MaxClusters; i++) begin
        bvalid[i] = 0;
        sem_label[i] = '0;
        sem_conf[i] = '0;
      end
      en_area = 0;
      en_x = 1;
      en_y = 0;
      keep_sem = 0;
      thresh = ibm_pkg::ThreshReset;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [17:0] data);
      case (index)
        ibm_pkg::REG_EN_AREA: en_area = data[0];
        ibm_pkg::REG_EN_X:    en_x = data[0];
        ibm_pkg::REG_EN_Y:    en_y = data[0];
        ibm_pkg::REG_KEEP:    keep_sem = data[0];
        ibm_pkg::REG_THRESH:  thresh = data;
        default: ;
      endcase
    endfunction

    // Truncated Q1.16 ratio; a zero denominator gives zero.
    function longint unsigned iou_ratio(longint unsigned ov, longint unsigned uni);
      if (uni == 0) return 0;
      return (ov << ibm_pkg::FracBits) / uni;
    endfunction

    function longint unsigned overlap_score(int i, box_req_t d);
      longint unsigned lo_x, lo_y, hi_x, hi_y, ea_x, eb_x, ea_y, eb_y;
      longint unsigned ov_x, ov_y, inter, s;
      lo_x = (bx[i] > d.x) ? bx[i] : d.x;
      lo_y = (by[i] > d.y) ? by[i] : d.y;
      ea_x = bx[i] + bw[i];
      eb_x = d.x + d.w;
      ea_y = by[i] + bh[i];
      eb_y = d.y + d.h;
      hi_x = (ea_x < eb_x) ? ea_x : eb_x;
      hi_y = (ea_y < eb_y) ? ea_y : eb_y;
      s = 0;
      if (hi_x < lo_x || hi_y < lo_y) return 0;
      ov_x = hi_x - lo_x;
      ov_y = hi_y - lo_y;
      if (en_area) begin
        inter = ov_x * ov_y;
        s += iou_ratio(inter, longint'(bw[i]) * bh[i] + longint'(d.w) * d.h - inter);
      end
      if (en_x) s += iou_ratio(ov_x, longint'(bw[i]) + d.w - ov_x);
      if (en_y) s += iou_ratio(ov_y, longint'(bh[i]) + d.h - ov_y);
      return s;
    endfunction

    function void note_request(box_req_t r);
      box_rsp_t        e;
      longint unsigned best, s;
      int              best_i;
      e = '{default: '0};
      case (r.op)
        ibm_pkg::OP_SET_SEM: begin
          sem_label[r.idx] = keep_sem ? r.label : 8'h0;
          sem_conf[r.idx] = keep_sem ? r.conf : 16'h0;
        end
        ibm_pkg::OP_NEW_CAM:
          for (int i = 0; i < ibm_pkg::MaxClusters; i++) bvalid[i] = 0;
        ibm_pkg::OP_LOAD_BOX: begin
          bx[r.idx] = r.x;
          by[r.idx] = r.y;
          bw[r.idx] = r.w;
          bh[r.idx] = r.h;
          bvalid[r.idx] = 1;
        end
        ibm_pkg::OP_MATCH: begin
          best = 0;
          best_i = 0;
          for (int i = 0; i < ibm_pkg::MaxClusters; i++) begin
            if (bvalid[i]) begin
              s = overlap_score(i, r);
              if (best < s) begin
                best = s;
                best_i = i;
              end
            end
          end
          e.matched = best > thresh;
          e.match_index = best_i[5:0];
          if (e.matched && sem_conf[best_i] <= r.conf) begin
            sem_label[best_i] = r.label;
            sem_conf[best_i] = r.conf;
            e.applied = 1;
          end
          e.best_score = best[17:0];
        end
        ibm_pkg::OP_READ: begin
          e.out_label = sem_label[r.idx];
          e.out_confidence = sem_conf[r.idx];
        end
        default: ;
      endcase
      pending_rsp = {pending_rsp, e};
    endfunction

    function void check_result(box_rsp_t got);
      box_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("result delivered with no request outstanding");
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (got.matched !== e.matched) begin
        $error("matched: expected %0d, got %0d", e.matched, got.matched);
        errors++;
      end
      if (got.match_index !== e.match_index) begin
        $error("match_index: expected %0d, got %0d", e.match_index, got.match_index);
        errors++;
      end
      if (got.applied !== e.applied) begin
        $error("applied: expected %0d, got %0d", e.applied, got.applied);
        errors++;
      end
      if (got.best_score !== e.best_score) begin
        $error("best_score: expected %0d, got %0d", e.best_score, got.best_score);
        errors++;
      end
      if (got.out_label !== e.out_label) begin
        $error("out_label: expected %0d, got %0d", e.out_label, got.out_label);
        errors++;
      end
      if (got.out_confidence !== e.out_confidence) begin
        $error("out_confidence: expected %0d, got %0d", e.out_confidence,
               got.out_confidence);
        errors++;
      end
    endfunction
  endclass

  // The limit covers every request being a full match with all three ratios on
  // under heavy result stalls, several times over.
  localparam longint unsigned CycleLimit = 20_000_000;
  localparam int unsigned     RandomItems = 400;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        req_valid_i = 0;
  logic        req_stall_o;
  logic [2:0]  opcode_i = '0;
  logic [5:0]  cluster_index_i = '0;
  logic [11:0] box_x_i = '0, box_y_i = '0, box_width_i = '0, box_height_i = '0;
  logic [7:0]  label_i = '0;
  logic [15:0] confidence_i = '0;
  logic        rsp_valid_o;
  logic        rsp_stall_i = 0;
  logic        matched_o, applied_o;
  logic [5:0]  match_index_o;
  logic [17:0] best_score_o;
  logic [7:0]  out_label_o;
  logic [15:0] out_confidence_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [17:0] cfg_data_i = '0;

  cluster_scoreboard sb = new();
  longint unsigned   cycle_count = 0;
  bit                hold_request = 0;
  bit                hold_sent = 0;
  int                burst_left = 0;

  iou_box_matcher DUT (.*);

  always #5 clk_i = ~clk_i;

  // Timeout guard: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result monitor. Outputs are read at the edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rsp_valid_o && !rsp_stall_i)
      sb.check_result('{matched_o, match_index_o, applied_o, best_score_o,
                        out_label_o, out_confidence_o});
  end

  // Receiver stall pattern. The stall rate is redrawn periodically among none,
  // light and heavy. When the stimulus asks for it, the receiver holds off for a
  // long stretch so that the block fills up and stalls the request channel.
  int          hold_left = 0;
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 600;
    end
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: rsp_stall_i <= 1'b0;
        1: rsp_stall_i <= ($urandom_range(0, 3) == 0);
        default: rsp_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Drives one request and waits for it to be taken. The sender works in bursts;
  // between bursts valid usually drops for a random gap.
  task automatic send_req(box_req_t r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        req_valid_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
    burst_left--;
    req_valid_i <= 1'b1;
    opcode_i <= r.op;
    cluster_index_i <= r.idx;
    box_x_i <= r.x;
    box_y_i <= r.y;
    box_width_i <= r.w;
    box_height_i <= r.h;
    label_i <= r.label;
    confidence_i <= r.conf;
    do @(posedge clk_i); while (req_stall_o);
    sb.note_request(r);
  endtask

  task automatic send_op(logic [2:0] op, logic [5:0] idx, logic [11:0] x, logic [11:0] y,
                         logic [11:0] w, logic [11:0] h, logic [7:0] label,
                         logic [15:0] conf);
    box_req_t r;
    r = '{op, idx, x, y, w, h, label, conf};
    send_req(r);
  endtask

  // Waits until every outstanding result is in, then lets the block settle.
  task automatic drain();
    req_valid_i <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] index, logic [17:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(index, data);
  endtask

  task automatic set_config(bit area, bit x, bit y, bit keep, logic [17:0] thr);
    write_cfg(ibm_pkg::REG_EN_AREA, {17'h0, area});
    write_cfg(ibm_pkg::REG_EN_X, {17'h0, x});
    write_cfg(ibm_pkg::REG_EN_Y, {17'h0, y});
    write_cfg(ibm_pkg::REG_KEEP, {17'h0, keep});
    write_cfg(ibm_pkg::REG_THRESH, thr);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [11:0] jitter(logic [11:0] v, int span);
    int t;
    t = int'(v) + $urandom_range(0, 2 * span) - span;
    if (t < 0) t = 0;
    if (t > 4095) t = 4095;
    return t[11:0];
  endfunction

  // A request with every field random.
  function automatic box_req_t random_req();
    box_req_t r;
    r.op = 3'($urandom);
    r.idx = 6'($urandom);
    r.x = 12'($urandom);
    r.y = 12'($urandom);
    r.w = 12'($urandom);
    r.h = 12'($urandom);
    r.label = 8'($urandom);
    r.conf = 16'($urandom);
    return r;
  endfunction

  // One camera frame: usually clear the boxes, load a handful of clusters, give some
  // of them a semantic, then match detections near the loaded boxes and read back.
  // A tenth of the requests after the loads are unrelated noise with fully random fields.
  task automatic random_frame(ref int issued);
    box_req_t    r, s;
    logic [5:0]  used[$];
    logic [11:0] lx[$], ly[$], lw[$], lh[$];
    int          n, k;
    used = {};
    if ($urandom_range(0, 4) != 0) begin
      r = random_req();
      r.op = ibm_pkg::OP_NEW_CAM;
      send_req(r);
      issued++;
    end
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      r = random_req();
      r.op = ibm_pkg::OP_LOAD_BOX;
      r.x = 12'($urandom_range(0, 3900));
      r.y = 12'($urandom_range(0, 3900));
      r.w = 12'($urandom_range(0, 300));
      r.h = 12'($urandom_range(0, 300));
      if ($urandom_range(0, 9) == 0) r.w = '0;
      used = {used, r.idx};
      lx = {lx, r.x};
      ly = {ly, r.y};
      lw = {lw, r.w};
      lh = {lh, r.h};
      send_req(r);
      if ($urandom_range(0, 1)) begin
        s = random_req();
        s.op = ibm_pkg::OP_SET_SEM;
        s.idx = r.idx;
        s.conf = 16'($urandom_range(0, 40000));
        send_req(s);
      end
      issued += 2;
    end
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, used.size() - 1);
      r = random_req();
      case ($urandom_range(0, 9))
        0: ;
        1, 2: begin
          r.op = ibm_pkg::OP_READ;
          r.idx = used[k];
        end
        default: begin
          r.op = ibm_pkg::OP_MATCH;
          r.x = jitter(lx[k], 20);
          r.y = jitter(ly[k], 20);
          r.w = jitter(lw[k], 20);
          r.h = jitter(lh[k], 20);
        end
      endcase
      send_req(r);
      issued++;
    end
  endtask

  int issued;

  initial begin
    sb.clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset configuration. The set request is zeroed while keep is
    // off; boxes at the coordinate extremes; identical, disjoint and touching
    // detections; a zero-size pair whose union is zero; two unknown opcodes; and a
    // match with no valid cluster after a new camera.
    send_op(ibm_pkg::OP_SET_SEM, 6'd63, '0, '0, '0, '0, 8'hFF, 16'hFFFF);
    send_op(ibm_pkg::OP_READ, 6'd63, '0, '0, '0, '0, '0, '0);
    send_op(ibm_pkg::OP_LOAD_BOX, 6'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, '0, '0);
    send_op(ibm_pkg::OP_LOAD_BOX, 6'd63, 12'd4095, 12'd4095, 12'd4095, 12'd4095, '0, '0);
    send_op(ibm_pkg::OP_LOAD_BOX, 6'd21, 12'd100, 12'd100, 12'd0, 12'd0, '0, '0);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd0, 12'd0, 12'd4095, 12'd4095, 8'hAA, 16'hFFFF);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'h55, 16'd0);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd4095, 12'd0, 12'd0, 12'd0, 8'h01, 16'd1);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd100, 12'd100, 12'd0, 12'd0, 8'h02, 16'd2);
    send_op(ibm_pkg::OP_READ, 6'd0, '0, '0, '0, '0, '0, '0);
    send_op(ibm_pkg::OP_READ, 6'd63, '0, '0, '0, '0, '0, '0);
    send_op(3'd5, 6'h2A, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 8'hFF, 16'hFFFF);
    send_op(3'd7, '0, '0, '0, '0, '0, '0, '0);
    send_op(ibm_pkg::OP_NEW_CAM, '0, '0, '0, '0, '0, '0, '0);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd0, 12'd0, 12'd4095, 12'd4095, 8'h11, 16'h1111);
    drain();

    // Keep on, every ratio enabled, zero threshold.
    set_config(1, 1, 1, 1, 18'd0);
    send_op(ibm_pkg::OP_SET_SEM, 6'd5, '0, '0, '0, '0, 8'hC3, 16'h8000);
    send_op(ibm_pkg::OP_LOAD_BOX, 6'd5, 12'd10, 12'd10, 12'd20, 12'd20, '0, '0);
    send_op(ibm_pkg::OP_LOAD_BOX, 6'd6, 12'd10, 12'd10, 12'd20, 12'd20, '0, '0);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd10, 12'd10, 12'd20, 12'd20, 8'h3C, 16'h7FFF);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd30, 12'd10, 12'd20, 12'd20, 8'h3C, 16'hFFFF);
    send_op(ibm_pkg::OP_MATCH, '0, 12'd15, 12'd15, 12'd20, 12'd20, 8'h3C, 16'hFFFF);
    send_op(ibm_pkg::OP_READ, 6'd5, '0, '0, '0, '0, '0, '0);
    send_op(ibm_pkg::OP_READ, 6'd6, '0, '0, '0, '0, '0, '0);
    drain();

    // Random part across several settings, the threshold extremes among them.
    issued = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(0, 1, 0, 1, ibm_pkg::ThreshReset);
        1: set_config(1, 0, 0, 0, 18'd196608);
        2: set_config(1, 1, 1, 1, 18'd65536);
        default: set_config(0, 0, 1, 1, 18'($urandom_range(0, 3000)));
      endcase
      while (issued < (phase + 1) * RandomItems / 4) begin
        if (phase == 1 && !hold_sent && issued >= RandomItems / 4 + 10) begin
          hold_sent = 1;
          hold_request = 1;
        end
        random_frame(issued);
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ibm_pkg.sv
design/ibm_divider.sv
design/iou_box_matcher.sv
tb/tb.sv
